// File: hdl/spcsr_pkg.sv
package spcsr_pkg;

  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned MaxEntries  = 4096;
  localparam int unsigned AdjDepth    = 2 * MaxEntries;
  localparam int unsigned OffDepth    = MaxVertices + 1;

  localparam int unsigned VtxW   = 11;  // 1-based vertex index and vertex_count
  localparam int unsigned IdxW   = 13;  // read_index
  localparam int unsigned ValW   = 14;  // offsets, cursors, result value
  localparam int unsigned StatW  = 2;
  localparam int unsigned EntAw  = $clog2(MaxEntries);
  localparam int unsigned CntW   = EntAw + 1;
  localparam int unsigned OffAw  = $clog2(OffDepth);
  localparam int unsigned CurAw  = $clog2(MaxVertices);
  localparam int unsigned AdjAw  = $clog2(AdjDepth);
  localparam int unsigned NbrW   = CurAw;

  typedef enum logic [1:0] {
    OpLoad    = 2'd0,
    OpBuild   = 2'd1,
    OpReadOff = 2'd2,
    OpReadAdj = 2'd3
  } op_e;

  localparam logic [StatW-1:0] StOk     = 2'd0;
  localparam logic [StatW-1:0] StReject = 2'd1;
  localparam logic [StatW-1:0] StRange  = 2'd2;

  // Entry checks produced by the shared unit
  typedef struct packed {
    logic in_range;  // both indices in 1..n
    logic off_diag;  // row differs from column
  } chk_t;

endpackage

// File: hdl/sparse_pattern_to_adjacency_csr_top.sv
// Sparse pattern to symmetric CSR adjacency graph.
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. operation selects load entry, build graph, read offset or
// read adjacency word. Each command returns exactly one result on value_o /
// status_o, marked by done_o for one cycle; the receiver cannot stall it, so
// no result is ever held back and no queue stands behind the result regs.
// APB port: register 0 (byte address 0) is vertex_count; write only while idle.
//
// A load, and a read of a zero or out-of-range slot, is answered from the
// dispatch state; a read of a stored offset or neighbor waits in SRdWait for
// the registered memory read. A build runs a clear pass, a count pass, a
// prefix pass and a scatter pass; the walk is set by one access per cycle
// on the offset and cursor memories and by the single shared adder. busy
// stays high until the result has been issued.
// Reset: entry list empty, vertex_count 1, no graph built (all offsets and
// the adjacency length read as zero). The build clears offsets 1..n itself.
module sparse_pattern_to_adjacency_csr_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   operation_i,
  input  logic [spcsr_pkg::VtxW-1:0]   row_index_i,
  input  logic [spcsr_pkg::VtxW-1:0]   col_index_i,
  input  logic [spcsr_pkg::IdxW-1:0]   read_index_i,
  // result channel
  output logic                         done_o,
  output logic [spcsr_pkg::ValW-1:0]   value_o,
  output logic [spcsr_pkg::StatW-1:0]  status_o,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import spcsr_pkg::*;

  localparam int unsigned StW = 4;
  localparam logic [StW-1:0] SIdle   = 4'd0;
  localparam logic [StW-1:0] SDisp   = 4'd1;
  localparam logic [StW-1:0] SRdWait = 4'd2;
  localparam logic [StW-1:0] SClr    = 4'd3;
  localparam logic [StW-1:0] SCntRd  = 4'd4;
  localparam logic [StW-1:0] SCntChk = 4'd5;
  localparam logic [StW-1:0] SCntR   = 4'd6;
  localparam logic [StW-1:0] SCntC   = 4'd7;
  localparam logic [StW-1:0] SPfxRd  = 4'd8;
  localparam logic [StW-1:0] SPfxWr  = 4'd9;
  localparam logic [StW-1:0] SScRd   = 4'd10;
  localparam logic [StW-1:0] SScChk  = 4'd11;
  localparam logic [StW-1:0] SScR    = 4'd12;
  localparam logic [StW-1:0] SScC    = 4'd13;

  // control state
  logic [StW-1:0]   state_q, state_d;
  logic [CntW-1:0]  ent_cnt_q, ent_cnt_d;
  logic [CntW-1:0]  e_q, e_d;
  logic [VtxW-1:0]  v_q, v_d;
  logic [ValW-1:0]  acc_q, acc_d;
  logic [VtxW-1:0]  vcount_q, vcount_d;
  logic [VtxW-1:0]  built_n_q, built_n_d;
  logic [ValW-1:0]  built_len_q, built_len_d;
  logic             done_q, done_d;

  // payload state
  op_e              op_q, op_d;
  logic [VtxW-1:0]  row_q, row_d;
  logic [VtxW-1:0]  col_q, col_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [ValW-1:0]  value_q, value_d;
  logic [StatW-1:0] status_q, status_d;

  // memory ports
  logic                ent_we;
  logic [2*VtxW-1:0]   ent_rd;
  logic                off_we;
  logic [OffAw-1:0]    off_waddr, off_raddr;
  logic [ValW-1:0]     off_wdata, off_rd;
  logic                cur_we;
  logic [CurAw-1:0]    cur_waddr, cur_raddr;
  logic [ValW-1:0]     cur_wdata, cur_rd;
  logic                adj_we;
  logic [AdjAw-1:0]    adj_waddr, adj_raddr;
  logic [NbrW-1:0]     adj_wdata, adj_rd;

  // shared unit
  logic [ValW-1:0]  add_a, add_b, sum;
  logic [VtxW-1:0]  chk_row, chk_col;
  chk_t             chk;

  logic [VtxW-1:0]  n_eff;
  logic [VtxW-1:0]  ent_r, ent_c;
  logic [VtxW-1:0]  v_m1, ent_r_m1, row_m1, col_m1;
  logic             cfg_wr;

  assign n_eff = (vcount_q > VtxW'(MaxVertices)) ? VtxW'(MaxVertices) : vcount_q;
  assign ent_r = ent_rd[2*VtxW-1:VtxW];
  assign ent_c = ent_rd[VtxW-1:0];
  assign v_m1     = v_q - VtxW'(1);
  assign ent_r_m1 = ent_r - VtxW'(1);
  assign row_m1   = row_q - VtxW'(1);
  assign col_m1   = col_q - VtxW'(1);

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {{(32-VtxW){1'b0}}, vcount_q};

  always_comb begin
    vcount_d = vcount_q;
    if (cfg_wr) begin
      vcount_d = pwdata[VtxW-1:0];
    end
  end

  // Operand select for the shared adder: increment a count or cursor, or
  // add the running prefix.
  always_comb begin
    add_a = ((state_q == SScR) || (state_q == SScC)) ? cur_rd : off_rd;
    add_b = (state_q == SPfxWr) ? acc_q : ValW'(1);
    chk_row = (state_q == SDisp) ? row_q : ent_r;
    chk_col = (state_q == SDisp) ? col_q : ent_c;
  end

  spcsr_alu u_alu (
    .add_a_i (add_a),
    .add_b_i (add_b),
    .row_i   (chk_row),
    .col_i   (chk_col),
    .n_i     (n_eff),
    .sum_o   (sum),
    .chk_o   (chk)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    ent_cnt_d   = ent_cnt_q;
    e_d         = e_q;
    v_d         = v_q;
    acc_d       = acc_q;
    built_n_d   = built_n_q;
    built_len_d = built_len_q;
    done_d      = 1'b0;
    op_d        = op_q;
    row_d       = row_q;
    col_d       = col_q;
    idx_d       = idx_q;
    value_d     = value_q;
    status_d    = status_q;

    ent_we    = 1'b0;
    off_we    = 1'b0;
    off_waddr = v_q;
    off_wdata = sum;
    off_raddr = v_q;
    cur_we    = 1'b0;
    cur_waddr = v_m1[CurAw-1:0];
    cur_wdata = sum;
    cur_raddr = row_m1[CurAw-1:0];
    adj_we    = 1'b0;
    adj_waddr = cur_rd[AdjAw-1:0];
    adj_wdata = col_m1[NbrW-1:0];
    adj_raddr = idx_q[AdjAw-1:0];

    unique case (state_q)
      SIdle: begin
        if (start) begin
          op_d    = op_e'(operation_i);
          row_d   = row_index_i;
          col_d   = col_index_i;
          idx_d   = read_index_i;
          state_d = SDisp;
        end
      end

      SDisp: begin
        unique case (op_q)
          OpLoad: begin
            done_d  = 1'b1;
            value_d = '0;
            state_d = SIdle;
            if ((ent_cnt_q >= CntW'(MaxEntries)) || !chk.in_range) begin
              status_d = StReject;
            end else begin
              status_d  = StOk;
              ent_we    = 1'b1;
              ent_cnt_d = ent_cnt_q + CntW'(1);
            end
          end
          OpBuild: begin
            v_d     = VtxW'(1);
            state_d = SClr;
          end
          OpReadOff: begin
            off_raddr = idx_q[OffAw-1:0];
            if (idx_q > IdxW'(n_eff)) begin
              done_d   = 1'b1;
              value_d  = '0;
              status_d = StRange;
              state_d  = SIdle;
            end else if ((idx_q == '0) || (idx_q > IdxW'(built_n_q))) begin
              // slot zero and slots past the last build hold zero
              done_d   = 1'b1;
              value_d  = '0;
              status_d = StOk;
              state_d  = SIdle;
            end else begin
              state_d = SRdWait;
            end
          end
          OpReadAdj: begin
            if (ValW'(idx_q) >= built_len_q) begin
              done_d   = 1'b1;
              value_d  = '0;
              status_d = StRange;
              state_d  = SIdle;
            end else begin
              state_d = SRdWait;
            end
          end
          default: state_d = SIdle;
        endcase
      end

      SRdWait: begin
        done_d   = 1'b1;
        status_d = StOk;
        value_d  = (op_q == OpReadOff) ? off_rd : ValW'(adj_rd);
        state_d  = SIdle;
      end

      SClr: begin
        off_wdata = '0;
        off_we    = (v_q <= n_eff);
        if (v_q >= n_eff) begin
          e_d     = '0;
          state_d = SCntRd;
        end else begin
          v_d = v_q + VtxW'(1);
        end
      end

      SCntRd: begin
        if (e_q == ent_cnt_q) begin
          v_d     = VtxW'(1);
          acc_d   = '0;
          state_d = SPfxRd;
        end else begin
          state_d = SCntChk;
        end
      end

      SCntChk: begin
        row_d     = ent_r;
        col_d     = ent_c;
        off_raddr = ent_r;
        if (chk.in_range && chk.off_diag) begin
          state_d = SCntR;
        end else begin
          e_d     = e_q + CntW'(1);
          state_d = SCntRd;
        end
      end

      SCntR: begin
        off_we    = 1'b1;
        off_waddr = row_q;
        off_raddr = col_q;
        state_d   = SCntC;
      end

      SCntC: begin
        off_we    = 1'b1;
        off_waddr = col_q;
        e_d       = e_q + CntW'(1);
        state_d   = SCntRd;
      end

      SPfxRd: begin
        if (v_q > n_eff) begin
          built_n_d   = n_eff;
          built_len_d = acc_q;
          e_d         = '0;
          state_d     = SScRd;
        end else begin
          state_d = SPfxWr;
        end
      end

      SPfxWr: begin
        // offsets[v] becomes the running sum, cursor[v-1] the sum before it
        off_we    = 1'b1;
        cur_we    = 1'b1;
        cur_wdata = acc_q;
        acc_d     = sum;
        v_d       = v_q + VtxW'(1);
        state_d   = SPfxRd;
      end

      SScRd: begin
        if (e_q == ent_cnt_q) begin
          done_d   = 1'b1;
          value_d  = built_len_q;
          status_d = StOk;
          state_d  = SIdle;
        end else begin
          state_d = SScChk;
        end
      end

      SScChk: begin
        row_d     = ent_r;
        col_d     = ent_c;
        cur_raddr = ent_r_m1[CurAw-1:0];
        if (chk.in_range && chk.off_diag) begin
          state_d = SScR;
        end else begin
          e_d     = e_q + CntW'(1);
          state_d = SScRd;
        end
      end

      SScR: begin
        adj_we    = !cur_rd[ValW-1];
        adj_wdata = col_m1[NbrW-1:0];
        cur_we    = 1'b1;
        cur_waddr = row_m1[CurAw-1:0];
        cur_raddr = col_m1[CurAw-1:0];
        state_d   = SScC;
      end

      SScC: begin
        adj_we    = !cur_rd[ValW-1];
        adj_wdata = row_m1[NbrW-1:0];
        cur_we    = 1'b1;
        cur_waddr = col_m1[CurAw-1:0];
        e_d       = e_q + CntW'(1);
        state_d   = SScRd;
      end

      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      ent_cnt_q   <= '0;
      e_q         <= '0;
      v_q         <= '0;
      acc_q       <= '0;
      vcount_q    <= VtxW'(1);
      built_n_q   <= '0;
      built_len_q <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      ent_cnt_q   <= ent_cnt_d;
      e_q         <= e_d;
      v_q         <= v_d;
      acc_q       <= acc_d;
      vcount_q    <= vcount_d;
      built_n_q   <= built_n_d;
      built_len_q <= built_len_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    row_q    <= row_d;
    col_q    <= col_d;
    idx_q    <= idx_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  spcsr_ram #(.Width(2*VtxW), .Depth(MaxEntries)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_cnt_q[EntAw-1:0]),
    .wdata_i ({row_q, col_q}),
    .raddr_i (e_q[EntAw-1:0]),
    .rdata_o (ent_rd)
  );

  spcsr_ram #(.Width(ValW), .Depth(OffDepth)) u_off_ram (
    .clk_i   (clk_i),
    .we_i    (off_we),
    .waddr_i (off_waddr),
    .wdata_i (off_wdata),
    .raddr_i (off_raddr),
    .rdata_o (off_rd)
  );

  spcsr_ram #(.Width(ValW), .Depth(MaxVertices)) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cur_we),
    .waddr_i (cur_waddr),
    .wdata_i (cur_wdata),
    .raddr_i (cur_raddr),
    .rdata_o (cur_rd)
  );

  spcsr_ram #(.Width(NbrW), .Depth(AdjDepth)) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rd)
  );

  assign busy     = (state_q != SIdle);
  assign done_o   = done_q;
  assign value_o  = value_q;
  assign status_o = status_q;

endmodule

// File: hdl/spcsr_ram.sv
module spcsr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/spcsr_alu.sv
module spcsr_alu (
  input  logic [spcsr_pkg::ValW-1:0] add_a_i,
  input  logic [spcsr_pkg::ValW-1:0] add_b_i,
  input  logic [spcsr_pkg::VtxW-1:0] row_i,
  input  logic [spcsr_pkg::VtxW-1:0] col_i,
  input  logic [spcsr_pkg::VtxW-1:0] n_i,
  output logic [spcsr_pkg::ValW-1:0] sum_o,
  output spcsr_pkg::chk_t            chk_o
);
  import spcsr_pkg::*;

  assign sum_o = add_a_i + add_b_i;

  assign chk_o.in_range = (row_i != '0) && (row_i <= n_i) &&
                          (col_i != '0) && (col_i <= n_i);
  assign chk_o.off_diag = (row_i != col_i);

endmodule
